@@ hw/rtl/mie_pkg.sv @@
// Package for the extended Euclidean modular inverse block.
// Holds the default operand width; no dependencies.
package mie_pkg;
  localparam int unsigned Width = 32;
endpackage

@@ hw/rtl/mie_divstep.sv @@
// Bit-serial shift-subtract divider with an MSB-first multiply-accumulate of the quotient.
// Depends on mie_pkg for the default width.
module mie_divstep #(
  parameter int unsigned WIDTH = mie_pkg::Width
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             step_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  input  logic [WIDTH-1:0] coef_i,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] acc_o
);
  logic [WIDTH-1:0] rem_q, rem_d, num_q, num_d, acc_q, acc_d;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             qbit;

  always_comb begin
    trial = {rem_q, num_q[WIDTH-1]};
    diff  = trial - {1'b0, divisor_i};
    qbit  = (trial >= {1'b0, divisor_i});
    rem_d = rem_q;
    num_d = num_q;
    acc_d = acc_q;
    if (start_i) begin
      rem_d = '0;
      num_d = dividend_i;
      acc_d = '0;
    end else if (step_i) begin
      // The partial remainder stays below the divisor, so the difference fits WIDTH bits.
      rem_d = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      num_d = {num_q[WIDTH-2:0], 1'b0};
      acc_d = {acc_q[WIDTH-2:0], 1'b0} + (qbit ? coef_i : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      num_q <= '0;
      acc_q <= '0;
    end else begin
      rem_q <= rem_d;
      num_q <= num_d;
      acc_q <= acc_d;
    end
  end

  assign rem_o = rem_q;
  assign acc_o = acc_q;
endmodule

@@ hw/rtl/modular_inverse_ext_euclid.sv @@
// Channel  | Signals                                   | Direction
// input    | in_valid_i, in_ready_o, value_i, modulus_i | word in
// output   | out_valid_o, out_ready_i, inverse_o, gcd_o | word out
// Each Euclid step tests for a zero remainder, runs the bit-serial divider, then
// updates remainders and coefficients.
// The block takes one word at a time; a finished word waits in the output register
// while the next input word is accepted. Reset is asynchronous and clears all control.
// Depends on mie_pkg and mie_divstep.
module modular_inverse_ext_euclid #(
  parameter int unsigned WIDTH = mie_pkg::Width
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] value_i,
  input  logic [WIDTH-1:0] modulus_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] inverse_o,
  output logic [WIDTH-1:0] gcd_o
);
  localparam int unsigned CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [2:0] {StIdle, StCheck, StDiv, StUpd, StDone} state_e;

  state_e           state_q;
  logic [CntW-1:0]  cnt_q;
  logic [WIDTH-1:0] rem_prev_q, rem_cur_q, coef_prev_q, coef_cur_q, modulus_q;
  logic             prev_neg_q;
  logic             out_valid_q;
  logic [WIDTH-1:0] inverse_q, gcd_q;
  logic [WIDTH-1:0] div_rem, div_acc;
  logic             div_start, div_step;

  assign div_start = (state_q == StCheck);
  assign div_step  = (state_q == StDiv);

  mie_divstep #(.WIDTH(WIDTH)) u_divstep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .step_i     (div_step),
    .dividend_i (rem_prev_q),
    .divisor_i  (rem_cur_q),
    .coef_i     (coef_cur_q),
    .rem_o      (div_rem),
    .acc_o      (div_acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      rem_prev_q  <= '0;
      rem_cur_q   <= '0;
      coef_prev_q <= '0;
      coef_cur_q  <= '0;
      modulus_q   <= '0;
      prev_neg_q  <= 1'b0;
      out_valid_q <= 1'b0;
      inverse_q   <= '0;
      gcd_q       <= '0;
    end else begin
      // In the done state a taken word is replaced by the new one below.
      if (out_valid_q && out_ready_i && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            modulus_q <= modulus_i;
            if (value_i > modulus_i) begin
              rem_prev_q  <= value_i;
              rem_cur_q   <= modulus_i;
              coef_prev_q <= {{(WIDTH-1){1'b0}}, 1'b1};
              coef_cur_q  <= '0;
              prev_neg_q  <= 1'b0;
            end else begin
              rem_prev_q  <= modulus_i;
              rem_cur_q   <= value_i;
              coef_prev_q <= '0;
              coef_cur_q  <= {{(WIDTH-1){1'b0}}, 1'b1};
              prev_neg_q  <= 1'b1;
            end
            state_q <= StCheck;
          end
        end
        StCheck: begin
          cnt_q   <= '0;
          state_q <= (rem_cur_q == '0) ? StDone : StDiv;
        end
        StDiv: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(WIDTH - 1)) begin
            state_q <= StUpd;
          end
        end
        StUpd: begin
          // Signs alternate, so the coefficient magnitudes only ever add.
          rem_prev_q  <= rem_cur_q;
          rem_cur_q   <= div_rem;
          coef_prev_q <= coef_cur_q;
          coef_cur_q  <= div_acc + coef_prev_q;
          prev_neg_q  <= !prev_neg_q;
          state_q     <= StCheck;
        end
        StDone: begin
          if (!out_valid_q || out_ready_i) begin
            inverse_q   <= (prev_neg_q && coef_prev_q != '0) ? modulus_q - coef_prev_q
                                                             : coef_prev_q;
            gcd_q       <= rem_prev_q;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign inverse_o   = inverse_q;
  assign gcd_o       = gcd_q;
endmodule

@@ hw/rtl/mie_checker.sv @@
// Port-level checks for the modular inverse block, bound to the top level.
// Depends on mie_pkg and on modular_inverse_ext_euclid's ports only.
module mie_checker #(
  parameter int unsigned WIDTH = mie_pkg::Width
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [WIDTH-1:0] inverse_o,
  input logic [WIDTH-1:0] gcd_o
);
  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(inverse_o) && $stable(gcd_o))
    else $error("output word changed while stalled");

  // Once a word is taken the block is busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // No result can appear on the cycle after an input is taken.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // A result is issued together with the return to idle.
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result issued without returning to idle");
endmodule

bind modular_inverse_ext_euclid mie_checker #(.WIDTH(WIDTH)) u_mie_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .inverse_o   (inverse_o),
  .gcd_o       (gcd_o)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the extended Euclidean modular inverse block.
// Predicts inverse and gcd per accepted word and checks results in order.
// Depends on mie_pkg and modular_inverse_ext_euclid.
module testbench;
  localparam int unsigned W = mie_pkg::Width;
  localparam int unsigned NumRandom = 370;
  localparam int unsigned StallLimit = 40000;

  typedef logic [W-1:0] word_t;
  typedef struct packed {
    word_t inverse;
    word_t gcd;
  } inv_result_t;

  class inverse_scoreboard;
    inv_result_t pending[$];
    int unsigned errors;
    int unsigned checked;

    // Coefficient magnitudes only ever add because their signs alternate.
    function inv_result_t solve_inverse(word_t v, word_t m);
      logic [W:0] rp, rc, cp, cc, cn, q, r;
      logic neg;
      inv_result_t res;
      if (v > m) begin
        rp = {1'b0, v};
        rc = {1'b0, m};
        cp = 1;
        cc = 0;
        neg = 1'b0;
      end else begin
        rp = {1'b0, m};
        rc = {1'b0, v};
        cp = 0;
        cc = 1;
        neg = 1'b1;
      end
      while (rc != 0) begin
        q = rp / rc;
        r = rp % rc;
        cn = {1'b0, word_t'(cp + q * cc)};
        rp = rc;
        rc = r;
        cp = cc;
        cc = cn;
        neg = !neg;
      end
      if (neg && cp != 0) res.inverse = word_t'(m - cp[W-1:0]);
      else res.inverse = cp[W-1:0];
      res.gcd = rp[W-1:0];
      return res;
    endfunction

    function void note_operands(word_t v, word_t m);
      pending.push_back(solve_inverse(v, m));
    endfunction

    task check_result(word_t inv, word_t g);
      inv_result_t exp_res;
      if (pending.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        exp_res = pending.pop_front();
        checked++;
        if (inv !== exp_res.inverse)
          report_mismatch($sformatf("inverse %h, expected %h", inv, exp_res.inverse));
        if (g !== exp_res.gcd)
          report_mismatch($sformatf("gcd %h, expected %h", g, exp_res.gcd));
      end
    endtask

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask
  endclass

  logic clk_i, rst_ni, in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  word_t value_i, modulus_i, inverse_o, gcd_o;
  inverse_scoreboard sb;
  bit stim_done;
  bit hold_off;
  int unsigned idle_cycles;

  modular_inverse_ext_euclid u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .value_i, .modulus_i,
    .out_valid_o, .out_ready_i, .inverse_o, .gcd_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom_range(0, 20));
      1: return '1 - word_t'($urandom_range(0, 3));
      2: return word_t'(1) << $urandom_range(0, W - 1);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic send_word(word_t v, word_t m);
    in_valid_i <= 1'b1;
    value_i <= v;
    modulus_i <= m;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_operands(v, m);
    @(negedge clk_i);
  endtask

  task automatic send_gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 3000)) @(negedge clk_i);
  endtask

  initial begin
    word_t dir_v[$], dir_m[$];
    int unsigned burst;
    sb = new();
    in_valid_i = 1'b0;
    value_i = '0;
    modulus_i = '0;
    rst_ni = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Zero operands, equal operands, both orderings and the extremes.
    dir_v = '{0, 0, 5, 7, '1, 3, 17, '1, 1, '1, 12, 2, 'h8000_0000, 65537};
    dir_m = '{0, 9, 0, 7, '1, 7, 3, 1, '1, 'hFFFF_FFFB, 18, 'h8000_0000, 3, 'hFFFF_FFFF};
    foreach (dir_v[i]) send_word(dir_v[i], dir_m[i]);
    for (int i = 0; i < NumRandom; ) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst && i < NumRandom; j++, i++) send_word(rand_word(), rand_word());
      if ($urandom_range(0, 1)) send_gap();
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // The long hold-off lets the output register fill so that the input stalls.
  initial begin
    out_ready_i = 1'b0;
    hold_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sb.checked == 6 && !hold_off) begin
        hold_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (8000) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0) || sb.checked > 300;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(inverse_o, gcd_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (stim_done && sb.pending.size() == 0) begin
        repeat (2000) @(posedge clk_i);
        if (out_valid_o) sb.report_mismatch("unexpected result word");
        $display("Checked %0d results from directed and random words,", sb.checked);
        $display("including zero, equal and extreme operands and a long output stall.");
        if (sb.errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
      end else if (idle_cycles >= StallLimit) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end
endmodule
